// ===== hw/rtl/dq_pkg.sv =====
// Shared constants, action codes and the cell command type of the double-ended queue.
package dq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int CNT_W_DEF     = $clog2(DEPTH_DEF + 1);

    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 2'd3;

    // At most one of these is set in a cycle; all clear means the row holds.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } dq_cmd_t;

endpackage

// ===== hw/rtl/dq_in_if.sv =====
// Input channel of the double-ended queue: one action and one data word per beat.
interface dq_in_if;
    logic                                valid;
    logic                                ready;
    logic [dq_pkg::ACTION_W-1:0]         action;
    logic signed [dq_pkg::FIELD_W-1:0]   value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== hw/rtl/dq_out_if.sv =====
// Result channel of the double-ended queue: end words, fill level and status flags.
interface dq_out_if #(
    parameter int CNT_W = dq_pkg::CNT_W_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [dq_pkg::FIELD_W-1:0]   front_word;
    logic signed [dq_pkg::FIELD_W-1:0]   back_word;
    logic [CNT_W-1:0]                    occupancy;
    logic                                is_empty;
    logic                                is_full;
    logic                                rejected;

    modport source (output valid, output front_word, output back_word, output occupancy,
                    output is_empty, output is_full, output rejected, input ready);
    modport sink   (input valid, input front_word, input back_word, input occupancy,
                    input is_empty, input is_full, input rejected, output ready);
endinterface

// ===== hw/rtl/dq_cell.sv =====
// One storage cell of the queue row: holds a word and a valid bit and trades them with its neighbours.
module dq_cell #(
    parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dq_pkg::dq_cmd_t      cmd,
    input  logic [WORD_BITS-1:0] push_word,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic                 left_valid,
    input  logic [WORD_BITS-1:0] right_word,
    input  logic                 right_valid,
    output logic [WORD_BITS-1:0] word,
    output logic                 valid,
    output logic                 tail
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 word_load;
    logic                 valid_reg;
    logic                 valid_next;

    always_comb
    begin
        word_next  = word_reg;
        word_load  = 1'b0;
        valid_next = valid_reg;
        priority if (cmd.push_front)
        begin
            word_next  = left_word;
            word_load  = 1'b1;
            valid_next = left_valid;
        end
        else if (cmd.push_back)
        begin
            // The first empty cell behind an occupied one takes the new word.
            if (!valid_reg && left_valid)
            begin
                word_next  = push_word;
                word_load  = 1'b1;
                valid_next = 1'b1;
            end
        end
        else if (cmd.pop_front)
        begin
            word_next  = right_word;
            word_load  = 1'b1;
            valid_next = right_valid;
        end
        else if (cmd.pop_back)
        begin
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_load)
        begin
            word_reg <= word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign word  = word_reg;
    assign valid = valid_reg;
    assign tail  = valid_reg && !right_valid;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Top level of the double-ended queue: a row of cells with the front at cell zero.
// The queue is a row of DEPTH cells with the front word always in cell zero: a push
// at the front shifts the whole row back by one cell, a pop at the front shifts it
// forward, and the back end is the last occupied cell. Each beat first shifts or
// loads the row; the result register then picks up the front cell and the tail
// cell through a one-hot select across the row. No new action is taken while a beat
// is in progress or while an offered result waits on a stalled sink; the result
// stays in its register while the sink stalls. Words are kept at WORD_BITS bits and
// are returned zero-extended; both end words read as zero when empty.
module double_ended_queue_unit #(
    parameter int  DEPTH     = dq_pkg::DEPTH_DEF,
    parameter int  WORD_BITS = dq_pkg::WORD_BITS_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic     clk,
    input  logic     rst_n,
    dq_in_if.sink    req,
    dq_out_if.source rsp
);

    localparam int EXT_W = 64;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 rej_reg;
    logic                 rej_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic [dq_pkg::FIELD_W-1:0] front_reg;
    logic [dq_pkg::FIELD_W-1:0] back_reg;
    logic [CNT_W-1:0]           occ_reg;
    logic                       empty_reg;
    logic                       full_reg;
    logic                       rejected_reg;

    logic                 accept;
    logic                 q_empty;
    logic                 q_full;
    logic                 is_push;
    logic                 allowed;
    dq_pkg::dq_cmd_t      cmd;
    logic [EXT_W-1:0]     value_ext;
    logic [WORD_BITS-1:0] push_word;

    logic [WORD_BITS-1:0] cell_word [DEPTH];
    logic [DEPTH-1:0]     cell_valid;
    logic [DEPTH-1:0]     cell_tail;
    logic [WORD_BITS-1:0] front_sel;
    logic [WORD_BITS-1:0] back_sel;
    logic [EXT_W-1:0]     front_ext;
    logic [EXT_W-1:0]     back_ext;

    assign req.ready = !busy_reg && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign q_empty = !cell_valid[0];
    assign q_full  = cell_valid[DEPTH-1];
    assign is_push = (req.action == dq_pkg::ACT_PUSH_FRONT)
                  || (req.action == dq_pkg::ACT_PUSH_BACK);
    assign allowed = is_push ? !q_full : !q_empty;

    assign value_ext = EXT_W'(unsigned'(req.value));
    assign push_word = value_ext[WORD_BITS-1:0];

    always_comb
    begin
        cmd        = '0;
        count_next = count_reg;
        if (accept && allowed)
        begin
            unique case (req.action)
                dq_pkg::ACT_PUSH_FRONT:
                begin
                    cmd.push_front = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                end
                dq_pkg::ACT_PUSH_BACK:
                begin
                    cmd.push_back = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                end
                dq_pkg::ACT_POP_FRONT:
                begin
                    cmd.pop_front = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                end
                dq_pkg::ACT_POP_BACK:
                begin
                    cmd.pop_back = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
    end

    // Cell zero sees an always-occupied neighbour that carries the pushed word, and
    // the last cell sees an empty one, so every cell runs the same rules.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic                 left_valid;
        logic [WORD_BITS-1:0] right_word;
        logic                 right_valid;

        if (i == 0)
        begin : g_first
            assign left_word  = push_word;
            assign left_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign left_word  = cell_word[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_word  = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_word  = cell_word[i+1];
            assign right_valid = cell_valid[i+1];
        end

        dq_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .push_word   (push_word),
            .left_word   (left_word),
            .left_valid  (left_valid),
            .right_word  (right_word),
            .right_valid (right_valid),
            .word        (cell_word[i]),
            .valid       (cell_valid[i]),
            .tail        (cell_tail[i])
        );
    end

    always_comb
    begin
        back_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_sel = back_sel | (cell_tail[i] ? cell_word[i] : '0);
        end
    end

    assign front_sel = cell_valid[0] ? cell_word[0] : '0;
    assign front_ext = EXT_W'(front_sel);
    assign back_ext  = EXT_W'(back_sel);

    always_comb
    begin
        busy_next      = busy_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (busy_reg)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            rej_next  = !allowed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rej_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rej_reg       <= rej_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            front_reg    <= front_ext[dq_pkg::FIELD_W-1:0];
            back_reg     <= back_ext[dq_pkg::FIELD_W-1:0];
            occ_reg      <= count_reg;
            empty_reg    <= !cell_valid[0];
            full_reg     <= cell_valid[DEPTH-1];
            rejected_reg <= rej_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.front_word = signed'(front_reg);
    assign rsp.back_word  = signed'(back_reg);
    assign rsp.occupancy  = occ_reg;
    assign rsp.is_empty   = empty_reg;
    assign rsp.is_full    = full_reg;
    assign rsp.rejected   = rejected_reg;

    // The row must stay packed towards the front: no occupied cell behind an empty one.
    a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("queue row has a gap");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(cell_valid)))
        else $error("word count disagrees with occupied cells");

    a_busy_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> out_valid_reg && !busy_reg)
        else $error("result not registered after the row update");

    a_one_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_tail) && ((cell_tail == '0) == q_empty))
        else $error("tail select is not one-hot");

    a_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (empty_reg == (occ_reg == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule
